### rtl/fsic_pkg.sv
`timescale 1ns / 1ps
// Package with the constants and item types of the first-seen index compactor.
package fsic_pkg;

    localparam int MAX_IDS = 4096;
    localparam int ID_AW   = $clog2(MAX_IDS);
    localparam int CNT_W   = $clog2(MAX_IDS + 1);

    localparam int ID_W    = 12;
    localparam int IDX_W   = 12;
    localparam int COUNT_W = 13;
    localparam int ENTRY_W = IDX_W + 1;

    localparam logic MODE_REF = 1'b0;
    localparam logic MODE_END = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] source_id;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   local_index;
        logic               is_new;
        logic [COUNT_W-1:0] group_count;
        logic               group_done;
    } t_out_item;

endpackage

### rtl/first_seen_index_compactor_core.sv
`timescale 1ns / 1ps
// Top level of the first-seen index compactor: remap table, touched list and sequencer.
//
// An item is taken when i_start is high and o_busy is low; its result appears on o_result
// for one cycle, marked by o_done, and cannot be held off. A reference item reads the remap
// table at acceptance and updates it in the next cycle (state S_LOOK, with o_busy high), and
// its result is registered at the end of S_LOOK; a reference to an id beyond the table gives
// its result in the cycle after acceptance. An end-of-group item gives its count in the cycle
// after acceptance and then keeps the block busy (not at all for an empty group) while the
// touched list is walked to clear the entries of the distinct ids of the group through the
// single write port of the remap table. After reset the block is busy while it clears every
// entry of the remap table (MAX_IDS, 4096 entries).
module first_seen_index_compactor_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fsic_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_done,
    output fsic_pkg::t_out_item o_result
);

    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [fsic_pkg::ENTRY_W-1:0] mem_remap [fsic_pkg::MAX_IDS];
    logic [fsic_pkg::ID_W-1:0]    mem_touch [fsic_pkg::MAX_IDS];

    logic [1:0]                   r_state;
    logic [fsic_pkg::CNT_W-1:0]   r_ptr;
    logic [fsic_pkg::CNT_W-1:0]   r_lim;
    logic [fsic_pkg::CNT_W-1:0]   r_next;
    logic [fsic_pkg::ID_W-1:0]    r_id;
    logic                         r_wr_pend;
    logic [fsic_pkg::ENTRY_W-1:0] r_remap_q;
    logic [fsic_pkg::ID_W-1:0]    r_touch_q;
    logic                         r_done;
    fsic_pkg::t_out_item          r_result;

    logic                         w_accept;
    logic                         w_in_range;
    logic                         w_miss;
    logic                         w_remap_we;
    logic [fsic_pkg::ID_AW-1:0]   w_remap_wa;
    logic [fsic_pkg::ENTRY_W-1:0] w_remap_wd;
    logic                         w_touch_re;

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    assign w_accept   = i_start && !o_busy;
    assign w_in_range = (32'(i_item.source_id) < fsic_pkg::MAX_IDS);
    assign w_miss     = (r_state == S_LOOK) && !r_remap_q[fsic_pkg::IDX_W]
                        && (32'(r_next) < fsic_pkg::MAX_IDS);
    assign w_touch_re = (r_state == S_CLEAR) && (r_ptr < r_lim);

    always_comb begin
        w_remap_we = 1'b0;
        w_remap_wa = '0;
        w_remap_wd = '0;
        case (r_state)
            S_INIT: begin
                w_remap_we = 1'b1;
                w_remap_wa = r_ptr[fsic_pkg::ID_AW-1:0];
            end
            S_LOOK: begin
                w_remap_we = w_miss;
                w_remap_wa = fsic_pkg::ID_AW'(r_id);
                w_remap_wd = {1'b1, fsic_pkg::IDX_W'(r_next)};
            end
            S_CLEAR: begin
                w_remap_we = r_wr_pend;
                w_remap_wa = fsic_pkg::ID_AW'(r_touch_q);
            end
            default: begin
                w_remap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_remap_we) begin
            mem_remap[w_remap_wa] <= w_remap_wd;
        end
        r_remap_q <= mem_remap[fsic_pkg::ID_AW'(i_item.source_id)];
    end

    always_ff @(posedge i_clk) begin
        if (w_miss) begin
            mem_touch[r_next[fsic_pkg::ID_AW-1:0]] <= r_id;
        end
        if (w_touch_re) begin
            r_touch_q <= mem_touch[r_ptr[fsic_pkg::ID_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_lim     <= '0;
            r_next    <= '0;
            r_wr_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= (w_accept && ((i_item.mode == fsic_pkg::MODE_END) || !w_in_range))
                      || (r_state == S_LOOK);
            case (r_state)
                S_INIT: begin
                    if (32'(r_ptr) == fsic_pkg::MAX_IDS - 1) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.mode == fsic_pkg::MODE_END) begin
                            r_result  <= '{'0, 1'b0, fsic_pkg::COUNT_W'(r_next), 1'b1};
                            r_lim     <= r_next;
                            r_next    <= '0;
                            r_ptr     <= '0;
                            r_wr_pend <= 1'b0;
                            if (r_next != '0) begin
                                r_state <= S_CLEAR;
                            end
                        end else if (w_in_range) begin
                            r_id    <= i_item.source_id;
                            r_state <= S_LOOK;
                        end else begin
                            r_result <= '0;
                        end
                    end
                end
                S_LOOK: begin
                    r_result <= '{w_miss ? fsic_pkg::IDX_W'(r_next)
                                         : r_remap_q[fsic_pkg::IDX_W-1:0],
                                  w_miss, '0, 1'b0};
                    if (w_miss) begin
                        r_next <= r_next + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    if (r_ptr < r_lim) begin
                        r_ptr     <= r_ptr + 1'b1;
                        r_wr_pend <= 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept) || $past(r_state == S_LOOK))
        else $error("result strobe without a preceding item or lookup");

    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_next) <= fsic_pkg::MAX_IDS)
        else $error("local index counter beyond the table size");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.group_done) |->
            (o_result.local_index == '0) && !o_result.is_new)
        else $error("end-of-group result carries reference fields");

    a_look_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_IDLE) && o_done)
        else $error("lookup did not complete in one cycle");

    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_ptr <= r_lim) && (r_next == '0))
        else $error("clearing walk out of bounds");

endmodule
